@@ hw/rtl/deq_pkg.sv @@
// shared types and constants of the double-ended queue
`default_nettype none
package deq_pkg;

  localparam int OP_BITS      = 3;
  localparam int VALUE_BITS   = 32;
  localparam int STATUS_BITS  = 2;
  localparam int OCC_BITS     = 5;
  localparam int S_TDATA_BITS = 32;
  localparam int M_TDATA_BITS = 40;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_REM_FRONT = 3'd1,
    OP_INS_REAR  = 3'd2,
    OP_REM_REAR  = 3'd3,
    OP_CLEAR     = 3'd4
  } deq_op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  typedef enum logic {
    S_IDLE,
    S_SEND
  } deq_state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } deq_cmd_t;

endpackage
`default_nettype wire

@@ hw/rtl/double_ended_queue_top.sv @@
// top level of the bounded double-ended queue
`default_nettype none
// Bounded double-ended queue of DEPTH items of ITEM_BITS bits in a circular
// buffer. Each input word carries an operation in s_tuser (insert front,
// remove front, insert rear, remove rear, clear) and the value to insert in
// s_tdata; each word returns one result word with the removed value (zero
// unless a removal succeeded), a status (done, empty on remove, full on
// insert) and the occupancy after the operation, cut to its low 5 bits.
// The result is offered in the cycle after its word is accepted: the
// accepting edge does the pointer update and the single-port slot memory
// access with its registered read, and the result register then drives
// m_tdata. A new word is taken in the cycle after the result is accepted,
// so no new word is taken while a result waits. Slots are not cleared at
// reset.
module double_ended_queue_top #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // value_in [31:0]
  input  wire logic [deq_pkg::S_TDATA_BITS-1:0]    s_tdata,
  // operation [2:0]
  input  wire logic [deq_pkg::OP_BITS-1:0]         s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // value_out [31:0], status [33:32], occupancy [38:34], zero [39]
  output logic      [deq_pkg::M_TDATA_BITS-1:0]    m_tdata
);
  import deq_pkg::*;

  deq_cmd_t                cmd;
  logic [VALUE_BITS-1:0]   value_out;
  logic [STATUS_BITS-1:0]  status;
  logic [OCC_BITS-1:0]     occupancy;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  deq_datapath #(
    .DEPTH     (DEPTH),
    .ITEM_BITS (ITEM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .operation (s_tuser),
    .value_in  (s_tdata),
    .value_out (value_out),
    .status    (status),
    .occupancy (occupancy)
  );

  assign m_tdata = {1'b0, occupancy, status, value_out};

endmodule
`default_nettype wire

@@ hw/rtl/deq_ctrl.sv @@
// handshake controller: take one word, then hold its result until taken
`default_nettype none
module deq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output deq_pkg::deq_cmd_t      cmd
);
  import deq_pkg::*;

  deq_state_t state;
  deq_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_SEND;
      end
      S_SEND: begin
        if (m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_SEND);
    cmd.exec = s_tvalid && (state == S_IDLE);
  end

endmodule
`default_nettype wire

@@ hw/rtl/deq_datapath.sv @@
// front pointer, item count, slot memory and result register
`default_nettype none
module deq_datapath #(
  parameter int DEPTH     = 16,
  parameter int ITEM_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire deq_pkg::deq_cmd_t                   cmd,
  input  wire logic [deq_pkg::OP_BITS-1:0]         operation,
  input  wire logic [deq_pkg::VALUE_BITS-1:0]      value_in,
  output logic      [deq_pkg::VALUE_BITS-1:0]      value_out,
  output logic      [deq_pkg::STATUS_BITS-1:0]     status,
  output logic      [deq_pkg::OCC_BITS-1:0]        occupancy
);
  import deq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [ITEM_BITS-1:0] mem [DEPTH];

  logic [PTR_W-1:0]     front;
  logic [PTR_W-1:0]     front_next;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  logic [ITEM_BITS-1:0] rd_data;
  logic                 got;
  logic                 got_next;
  deq_status_t          status_q;
  deq_status_t          status_next;
  logic [OCC_BITS-1:0]  occ_q;

  logic                 wr_en;
  logic [PTR_W-1:0]     addr;
  logic [ITEM_BITS-1:0] wdata;

  logic [SUM_W-1:0]     rear_sum;
  logic [SUM_W-1:0]     last_sum;
  logic [PTR_W-1:0]     rear_slot;
  logic [PTR_W-1:0]     last_slot;
  logic [PTR_W-1:0]     prev_front;
  logic [PTR_W-1:0]     succ_front;
  logic                 full;
  logic                 empty;
  logic signed [63:0]   in_ext;
  logic signed [63:0]   out_ext;
  deq_op_t              op;

  always_comb begin
    full       = (count == CNT_W'(DEPTH));
    empty      = (count == '0);
    // slot after the last item, and the last item itself, wrapping once
    rear_sum   = SUM_W'(front) + SUM_W'(count);
    last_sum   = rear_sum - SUM_W'(1);
    rear_slot  = (rear_sum >= SUM_W'(DEPTH)) ? PTR_W'(rear_sum - SUM_W'(DEPTH))
                                             : PTR_W'(rear_sum);
    last_slot  = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
                                             : PTR_W'(last_sum);
    prev_front = (front == '0) ? PTR_W'(DEPTH - 1) : front - PTR_W'(1);
    succ_front = (front == PTR_W'(DEPTH - 1)) ? '0 : front + PTR_W'(1);
    in_ext     = 64'(signed'(value_in));
    wdata      = in_ext[ITEM_BITS-1:0];
    op         = deq_op_t'(operation);
  end

  always_comb begin
    front_next  = front;
    count_next  = count;
    wr_en       = 1'b0;
    addr        = front;
    got_next    = 1'b0;
    status_next = ST_DONE;
    unique case (op)
      OP_INS_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          front_next = prev_front;
          addr       = prev_front;
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = front;
          got_next   = 1'b1;
          front_next = succ_front;
          count_next = count - CNT_W'(1);
        end
      end
      OP_INS_REAR: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          addr       = rear_slot;
          wr_en      = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      OP_REM_REAR: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          addr       = last_slot;
          got_next   = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        front_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) mem[addr] <= wdata;
      rd_data  <= mem[addr];
      got      <= got_next;
      status_q <= status_next;
      occ_q    <= OCC_BITS'(count_next);
    end
  end

  always_comb begin
    out_ext   = 64'(signed'(rd_data));
    value_out = got ? out_ext[VALUE_BITS-1:0] : '0;
    status    = status_q;
    occupancy = occ_q;
  end

endmodule
`default_nettype wire

@@ tb/double_ended_queue_top_test.sv @@
// self-checking testbench for the double-ended queue: directed cases and random operation streams with a scoreboard
`default_nettype none
module double_ended_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int ITEM_BITS = 32;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_WORDS = 2000;
  localparam logic [OP_BITS-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [OP_BITS-1:0] OP_LAST_UNUSED = 3'd7;
  localparam logic [VALUE_BITS-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_BITS-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_BITS-1:0] VAL_ONES = 32'hffff_ffff;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED
  } traffic_mode_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    deq_status_t           status;
    logic [OCC_BITS-1:0]   occupancy;
  } deq_result_t;

  // mirror of the deque contents and the results it must produce
  class deque_scoreboard;
    logic [VALUE_BITS-1:0] slots [DEPTH];
    logic [3:0]            head;
    logic [OCC_BITS-1:0]   held;
    deq_result_t           due [$];
    int                    errors;

    function new();
      head = '0;
      held = '0;
      errors = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    // apply one accepted operation to the mirror and queue its result
    function void note_word(logic [OP_BITS-1:0] op, logic [VALUE_BITS-1:0] val);
      deq_result_t r;
      r.value = '0;
      r.status = ST_DONE;
      case (op)
        OP_INS_FRONT: begin
          if (held == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            head = head - 4'd1;
            slots[head] = val;
            held = held + 1'b1;
          end
        end
        OP_REM_FRONT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = slots[head];
            head = head + 4'd1;
            held = held - 1'b1;
          end
        end
        OP_INS_REAR: begin
          if (held == DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slots[4'(head + held[3:0])] = val;
            held = held + 1'b1;
          end
        end
        OP_REM_REAR: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.value = slots[4'(head + 4'(held - 1'b1))];
            held = held - 1'b1;
          end
        end
        OP_CLEAR: begin
          held = '0;
          head = '0;
        end
        default: ;
      endcase
      r.occupancy = held;
      due.push_back(r);
    endfunction

    function void check_word(logic [M_TDATA_BITS-1:0] w);
      deq_result_t e;
      if (due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, w);
        errors++;
        return;
      end
      e = due.pop_front();
      if (w[31:0] !== e.value) begin
        $display("%0t: value_out mismatch, expected %h, actual %h", $time, e.value, w[31:0]);
        errors++;
      end
      if (w[33:32] !== e.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, e.status, w[33:32]);
        errors++;
      end
      if (w[38:34] !== e.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                 $time, e.occupancy, w[38:34]);
        errors++;
      end
      if (w[39] !== 1'b0) begin
        $display("%0t: pad bit mismatch, expected 0, actual %b", $time, w[39]);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [S_TDATA_BITS-1:0]   s_tdata = '0;
  logic [OP_BITS-1:0]        s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [M_TDATA_BITS-1:0]   m_tdata;

  deque_scoreboard board = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_cycles = 0;

  double_ended_queue_top #(
    .DEPTH(DEPTH),
    .ITEM_BITS(ITEM_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // called just after a falling edge, returns just after a falling edge
  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [VALUE_BITS-1:0] val);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = val;
    s_tuser = op;
    do @(posedge clk); while (!s_tready);
    board.note_word(op, val);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(15, 0))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return VAL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_BITS-1:0] pick_op(traffic_mode_t mode);
    int roll;
    int ins_pct;
    roll = $urandom_range(199, 0);
    if (roll < 3) return OP_CLEAR;
    if (roll < 6) return 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    ins_pct = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 22 : 50;
    if ($urandom_range(99, 0) < ins_pct) return $urandom_range(1, 0) ? OP_INS_FRONT : OP_INS_REAR;
    return $urandom_range(1, 0) ? OP_REM_FRONT : OP_REM_REAR;
  endfunction

  task automatic run_random(int count);
    traffic_mode_t mode;
    int            left;
    mode = MODE_MIXED;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        mode = traffic_mode_t'($urandom_range(2, 0));
        left = $urandom_range(80, 20);
      end
      left--;
      if ($urandom_range(149, 0) == 0) wait_drained();
      send_word(pick_op(mode), pick_value());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 32;
    recv_idle_pct = 54;
    // empty deque, unused codes, then single-item and extreme-value cases
    send_word(OP_REM_FRONT, VAL_ONES);
    send_word(OP_REM_REAR, VAL_MAX);
    send_word(OP_CLEAR, VAL_MIN);
    for (logic [OP_BITS:0] c = {1'b0, OP_FIRST_UNUSED}; c <= {1'b0, OP_LAST_UNUSED}; c++)
      send_word(c[OP_BITS-1:0], VAL_ONES);
    send_word(OP_INS_REAR, VAL_MIN);
    send_word(OP_REM_FRONT, '0);
    send_word(OP_INS_FRONT, VAL_MAX);
    send_word(OP_REM_REAR, '0);
    send_word(OP_INS_REAR, VAL_ONES);
    send_word(OP_INS_FRONT, '0);
    send_word(OP_INS_REAR, 32'h5555_5555);
    send_word(OP_INS_FRONT, 32'haaaa_aaaa);
    send_word(OP_FIRST_UNUSED, 32'h1234_5678);
    send_word(OP_REM_FRONT, '0);
    send_word(OP_REM_REAR, '0);
    send_word(OP_CLEAR, '0);
    send_word(OP_REM_FRONT, '0);
    send_word(OP_INS_FRONT, 32'd1);
    send_word(OP_REM_FRONT, '0);

    run_random(RANDOM_WORDS / 3);
    wait_drained();
    send_idle_pct = 54;
    recv_idle_pct = 32;
    run_random(RANDOM_WORDS / 3);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
